// ===== design/ipoc_pkg.sv =====
// Shared widths, codes and helpers for the IPv4 prefix overlap checker.
`default_nettype none

package ipoc_pkg;

    localparam int ACT_W     = 2;
    localparam int NET_W     = 32;
    localparam int LEN_W     = 6;
    localparam int HOST_W    = 33;
    localparam int STAT_W    = 3;
    localparam int ENT_W     = 9;
    localparam int SUM_W     = 41;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 41;
    localparam int MINCNT_W  = 9;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [NET_W-1:0]  t_net;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [HOST_W-1:0] t_hosts;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [ENT_W-1:0]  t_entries;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [NET_W:0]    t_addr_ext;

    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_ADD    = 2'd1;
    localparam t_action ACT_FINISH = 2'd2;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_OVERLAP   = 3'd2;
    localparam t_status ST_MALFORMED = 3'd3;
    localparam t_status ST_EMPTY     = 3'd4;
    localparam t_status ST_SMALL     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOSTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENFORCE   = 2'd2;

    localparam t_len                MAX_LEN       = 6'd32;
    localparam t_sum                SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [MINCNT_W-1:0] RST_MIN_COUNT = 9'd8;
    localparam t_sum                RST_MIN_HOSTS = 41'd65536;

    // Last address of a prefix, one bit wider so that it never wraps.
    function automatic t_addr_ext range_top(t_net base, t_len len);
        t_addr_ext span;
        span = (t_addr_ext'(1) << (MAX_LEN - len)) - t_addr_ext'(1);
        return {1'b0, base} + span;
    endfunction

endpackage

`default_nettype wire

// ===== design/ipoc_in_if.sv =====
// Input channel of the prefix checker: one action item per handshake.
`default_nettype none

interface ipoc_in_if;
    import ipoc_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_net    network;
    t_len    prefix_len;
    t_hosts  host_count;
    logic    malformed;

    modport source (output valid, action, network, prefix_len, host_count, malformed,
                    input ready);
    modport sink   (input valid, action, network, prefix_len, host_count, malformed,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ipoc_out_if.sv =====
// Result channel of the prefix checker: one result item per input item.
`default_nettype none

interface ipoc_out_if;
    import ipoc_pkg::*;

    logic     valid;
    logic     ready;
    t_status  status;
    t_entries entries_stored;
    t_sum     host_total;
    logic     list_ok;

    modport source (output valid, status, entries_stored, host_total, list_ok,
                    input ready);
    modport sink   (input valid, status, entries_stored, host_total, list_ok,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ipv4_prefix_overlap_checker.sv =====
// IPv4 prefix overlap checker.
// Items arrive on i_item (valid/ready): clear, add prefix or finish list.
// Every input item yields exactly one result item on o_res (valid/ready).
// Prefixes live in one RAM with a registered read. An add that
// gets past the full, malformed and latched-error checks walks the stored
// entries through the single read port, one per cycle, stopping early on
// an overlap; a full table is refused at once. Clear, finish, ignored
// adds, unused action codes and immediate errors are answered directly
// on acceptance, without a table walk. One item is worked on at a time.
// The result sits in an output register; a stalled receiver holds it there,
// and the block takes no new item until that register can be refilled.
// Configuration writes on i_cfg_* take effect at the next clock edge and
// should only come while the block is idle.
// Synchronous reset empties the table, zeroes count, total and latched
// error, and restores the register defaults (8 prefixes, 65536 hosts,
// minimums enforced). No clearing pass is needed; RAM contents beyond the
// stored count are never used.
`default_nettype none

module ipv4_prefix_overlap_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ipoc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ipoc_pkg::CFG_W-1:0]      i_cfg_wdata,
    ipoc_in_if.sink                              i_item,
    ipoc_out_if.source                           o_res
);
    import ipoc_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW  = (CW > MINCNT_W) ? CW : MINCNT_W;
    localparam int ENT_DW = NET_W + LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Control state.
    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    t_sum                r_sum, n_sum;
    t_status             r_err, n_err;
    logic [CW-1:0]       r_issue, n_issue;
    logic                r_rvalid, n_rvalid;
    logic                r_hit, n_hit;
    logic                r_out_valid, n_out_valid;

    // Configuration.
    logic [MINCNT_W-1:0] r_min_count;
    t_sum                r_min_hosts;
    logic                r_enforce;

    // Item and result payload.
    t_net                r_net, n_net;
    t_len                r_len, n_len;
    t_hosts              r_hosts, n_hosts;
    t_addr_ext           r_top, n_top;
    t_status             r_status, n_status;
    t_entries            r_entries, n_entries;
    t_sum                r_total, n_total;
    logic                r_ok, n_ok;

    logic                w_acc;
    logic                w_slot_free;
    logic                w_load;
    logic                w_we;
    logic [ENT_DW-1:0]   w_rdata;
    t_net                w_sbase;
    t_len                w_slen;
    logic                w_meet;
    logic [SUM_W:0]      w_sum_ext;
    t_sum                w_sum_sat;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_item.ready = (r_state == S_IDLE) && w_slot_free;
    assign w_acc = i_item.valid && i_item.ready;

    assign w_we = (r_state == S_POST) && w_slot_free && !r_hit;

    ipoc_ram #(
        .WIDTH (ENT_DW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_net, r_len}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_sbase = w_rdata[ENT_DW-1:LEN_W];
    assign w_slen  = w_rdata[LEN_W-1:0];
    assign w_meet  = ({1'b0, w_sbase} <= r_top) && ({1'b0, r_net} <= range_top(w_sbase, w_slen));

    assign w_sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_hosts);
    assign w_sum_sat = (w_sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : w_sum_ext[SUM_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_err       = r_err;
        n_issue     = r_issue;
        n_rvalid    = r_rvalid;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_net       = r_net;
        n_len       = r_len;
        n_hosts     = r_hosts;
        n_top       = r_top;
        n_status    = r_status;
        n_entries   = r_entries;
        n_total     = r_total;
        n_ok        = r_ok;
        w_load      = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_net   = i_item.network;
                    n_len   = i_item.prefix_len;
                    n_hosts = i_item.host_count;
                    n_top   = range_top(i_item.network, i_item.prefix_len);
                    w_load  = 1'b1;
                    n_status = r_err;
                    n_ok    = 1'b0;
                    case (i_item.action)
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_sum    = '0;
                            n_err    = ST_OK;
                            n_status = ST_OK;
                        end
                        ACT_ADD: begin
                            if (r_err != ST_OK) begin
                                n_status = r_err;
                            end else if (r_count >= DEPTH_C) begin
                                n_err    = ST_FULL;
                                n_status = ST_FULL;
                            end else if (i_item.malformed || i_item.prefix_len > MAX_LEN) begin
                                n_err    = ST_MALFORMED;
                                n_status = ST_MALFORMED;
                            end else begin
                                // The result comes after the table walk.
                                w_load   = 1'b0;
                                n_state  = S_SCAN;
                                n_issue  = '0;
                                n_rvalid = 1'b0;
                                n_hit    = 1'b0;
                            end
                        end
                        ACT_FINISH: begin
                            if (r_err != ST_OK) begin
                                n_status = r_err;
                            end else if (r_count == '0 || r_sum == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_enforce && (CMPW'(r_count) < CMPW'(r_min_count) ||
                                                       r_sum < r_min_hosts)) begin
                                n_status = ST_SMALL;
                            end else begin
                                n_status = ST_OK;
                                n_ok     = 1'b1;
                            end
                        end
                        default: begin
                            n_status = r_err;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issue < r_count) begin
                    n_issue  = r_issue + CW'(1);
                    n_rvalid = 1'b1;
                end else begin
                    n_rvalid = 1'b0;
                end
                if (r_rvalid && w_meet) begin
                    n_hit    = 1'b1;
                    n_rvalid = 1'b0;
                    n_state  = S_POST;
                end else if (!r_rvalid && r_issue == r_count) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_ok    = 1'b0;
                    n_state = S_IDLE;
                    if (r_hit) begin
                        n_err    = ST_OVERLAP;
                        n_status = ST_OVERLAP;
                    end else begin
                        n_count  = r_count + CW'(1);
                        n_sum    = w_sum_sat;
                        n_status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_entries   = ENT_W'(n_count);
            n_total     = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_err       <= ST_OK;
            r_issue     <= '0;
            r_rvalid    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_min_count <= RST_MIN_COUNT;
            r_min_hosts <= RST_MIN_HOSTS;
            r_enforce   <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_err       <= n_err;
            r_issue     <= n_issue;
            r_rvalid    <= n_rvalid;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_COUNT: r_min_count <= i_cfg_wdata[MINCNT_W-1:0];
                    CFG_MIN_HOSTS: r_min_hosts <= i_cfg_wdata[SUM_W-1:0];
                    CFG_ENFORCE:   r_enforce   <= i_cfg_wdata[0];
                    default:       r_enforce   <= r_enforce;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_net     <= n_net;
        r_len     <= n_len;
        r_hosts   <= n_hosts;
        r_top     <= n_top;
        r_status  <= n_status;
        r_entries <= n_entries;
        r_total   <= n_total;
        r_ok      <= n_ok;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.entries_stored = r_entries;
    assign o_res.host_total     = r_total;
    assign o_res.list_ok        = r_ok;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stored count exceeds table depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_count))
        else $error("table walk ran past the stored count");

    a_error_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !(w_acc && i_item.action == ACT_CLEAR)) |=> $stable(r_count))
        else $error("table changed while an error was latched");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> (r_status == ST_OK))
        else $error("list_ok set with a failing status");
`endif

endmodule

`default_nettype wire

// ===== design/ipoc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ipoc_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== bench/ipv4_prefix_overlap_checker_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 prefix overlap checker: directed table, a full-table fill, then random lists.
module ipv4_prefix_overlap_checker_tb;
    import ipoc_pkg::*;

    localparam int      DEPTH         = 256;
    localparam int      DIRECTED_ROWS = 25;
    localparam int      PHASES        = 7;
    localparam int      PHASE_ITEMS   = 40;
    localparam t_action ACT_UNUSED    = 2'd3;
    localparam t_hosts  HOSTS_4G      = 33'h1_0000_0000;
    localparam t_sum    SUM_4G        = 41'h1_0000_0000;
    localparam t_sum    SUM_1T        = 41'h100_0000_0000;

    typedef struct packed {
        t_action action;
        t_net    network;
        t_len    prefix_len;
        t_hosts  host_count;
        logic    malformed;
    } t_item;

    typedef struct packed {
        t_status  status;
        t_entries entries;
        t_sum     total;
        logic     ok;
    } t_result;

    typedef struct {
        t_action  action;
        t_net     network;
        t_len     prefix_len;
        t_hosts   host_count;
        logic     malformed;
        bit       known;
        t_status  status;
        t_entries entries;
        t_sum     total;
        logic     ok;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    ipoc_in_if  in_ch ();
    ipoc_out_if out_ch ();

    ipv4_prefix_overlap_checker #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_ch),
        .o_res       (out_ch)
    );

    // Shadow copy of the prefix table, totals and limits.
    t_net        stored_base [DEPTH];
    t_len        stored_len  [DEPTH];
    int unsigned stored_n;
    t_sum        host_sum;
    t_status     held_error;
    t_entries    cfg_min_count;
    t_sum        cfg_min_hosts;
    logic        cfg_enforce;

    t_result expected_results [$];
    int      mismatch_count;
    int      sent_count;
    bit      tx_calm;
    bit      rx_calm;
    bit      long_hold_req;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{ACT_FINISH, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_EMPTY,     9'd0, 41'd0,  1'b0},
        '{ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 33'h1_FFFF_FFFF, 1'b1, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0000_0000, 6'd32, 33'd0,           1'b0, 1'b1, ST_OK,        9'd1, 41'd0,  1'b0},
        '{ACT_FINISH, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_EMPTY,     9'd1, 41'd0,  1'b0},
        '{ACT_ADD,    32'hFFFF_FFFF, 6'd32, HOSTS_4G,        1'b0, 1'b1, ST_OK,        9'd2, SUM_4G, 1'b0},
        '{ACT_FINISH, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_SMALL,     9'd2, SUM_4G, 1'b0},
        '{ACT_ADD,    32'h0A00_0000, 6'd8,  33'h1_FFFF_FFFF, 1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0A01_0000, 6'd16, 33'd5,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'hC0A8_0000, 6'd16, 33'd7,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_FINISH, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_CLEAR,  32'hFFFF_FFFF, 6'd63, 33'h1_FFFF_FFFF, 1'b1, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0000_0000, 6'd33, 33'd1,           1'b0, 1'b1, ST_MALFORMED, 9'd0, 41'd0,  1'b0},
        '{ACT_UNUSED, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_MALFORMED, 9'd0, 41'd0,  1'b0},
        '{ACT_CLEAR,  32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'hC0A8_0100, 6'd24, 33'd256,         1'b1, 1'b1, ST_MALFORMED, 9'd0, 41'd0,  1'b0},
        '{ACT_CLEAR,  32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0000_0000, 6'd0,  HOSTS_4G,        1'b0, 1'b1, ST_OK,        9'd1, SUM_4G, 1'b0},
        '{ACT_ADD,    32'hC0A8_0100, 6'd24, 33'd256,         1'b0, 1'b1, ST_OVERLAP,   9'd1, SUM_4G, 1'b0},
        '{ACT_CLEAR,  32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0A00_0005, 6'd24, 33'd256,         1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0A00_0100, 6'd24, 33'd256,         1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_CLEAR,  32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b1, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'hFFFF_FF80, 6'd24, 33'd1,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_ADD,    32'h0000_0000, 6'd24, 33'd1,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0},
        '{ACT_FINISH, 32'h0000_0000, 6'd0,  33'd0,           1'b0, 1'b0, ST_OK,        9'd0, 41'd0,  1'b0}
    };

    function automatic t_net prefix_mask(t_len len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // Ranges are compared in 64 bits so that a top end past the address space does not wrap.
    function automatic bit ranges_touch(t_net a_base, t_len a_len, t_net b_base, t_len b_len);
        longint unsigned a_lo, a_hi, b_lo, b_hi;
        a_lo = a_base;
        b_lo = b_base;
        a_hi = a_lo + (64'd1 << (32 - a_len)) - 64'd1;
        b_hi = b_lo + (64'd1 << (32 - b_len)) - 64'd1;
        return (a_lo <= b_hi) && (b_lo <= a_hi);
    endfunction

    function automatic t_result predict_prefix(t_item it);
        t_result     r;
        logic [41:0] wide_sum;
        r.status = held_error;
        r.ok     = 1'b0;
        case (it.action)
            ACT_CLEAR: begin
                stored_n   = 0;
                host_sum   = '0;
                held_error = ST_OK;
                r.status   = ST_OK;
            end
            ACT_ADD: begin
                if (held_error == ST_OK) begin
                    if (stored_n >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (it.malformed || it.prefix_len > MAX_LEN) begin
                        r.status = ST_MALFORMED;
                    end else begin
                        r.status = ST_OK;
                        for (int i = 0; i < stored_n && r.status == ST_OK; i++) begin
                            if (ranges_touch(stored_base[i], stored_len[i], it.network,
                                             it.prefix_len)) begin
                                r.status = ST_OVERLAP;
                            end
                        end
                    end
                    if (r.status == ST_OK) begin
                        stored_base[stored_n] = it.network;
                        stored_len[stored_n]  = it.prefix_len;
                        stored_n++;
                        wide_sum = {1'b0, host_sum} + 42'(it.host_count);
                        if (wide_sum > 42'(SUM_MAX)) begin
                            wide_sum = 42'(SUM_MAX);
                        end
                        host_sum = wide_sum[SUM_W-1:0];
                    end else begin
                        held_error = r.status;
                    end
                end
            end
            ACT_FINISH: begin
                if (held_error == ST_OK) begin
                    if (stored_n == 0 || host_sum == '0) begin
                        r.status = ST_EMPTY;
                    end else if (cfg_enforce &&
                                 (stored_n < cfg_min_count || host_sum < cfg_min_hosts)) begin
                        r.status = ST_SMALL;
                    end else begin
                        r.status = ST_OK;
                        r.ok     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entries = t_entries'(stored_n);
        r.total   = host_sum;
        return r;
    endfunction

    // Mostly zero or short, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_hosts random_hosts();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return t_hosts'($urandom_range(1, 1024));
            2:       return HOSTS_4G;
            default: return {1'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic t_item fresh_prefix();
        t_item it;
        it.action     = ACT_ADD;
        it.malformed  = 1'b0;
        it.prefix_len = ($urandom_range(0, 9) == 0) ? t_len'($urandom_range(0, 32))
                                                    : t_len'($urandom_range(14, 32));
        it.network    = $urandom;
        // Most networks are aligned; the rest start mid-range.
        if ($urandom_range(0, 6) != 0) begin
            it.network &= prefix_mask(it.prefix_len);
        end
        it.host_count = random_hosts();
        return it;
    endfunction

    // A prefix inside the aligned block of a stored one (a fresh one if none is stored), so that it mostly collides.
    function automatic t_item nested_prefix();
        t_item it;
        int    j;
        t_net  outer;
        it = fresh_prefix();
        if (stored_n != 0) begin
            j             = $urandom_range(0, stored_n - 1);
            outer         = prefix_mask(stored_len[j]);
            it.prefix_len = t_len'($urandom_range(stored_len[j], 32));
            it.network    = ((stored_base[j] & outer) | ($urandom & ~outer))
                            & prefix_mask(it.prefix_len);
        end
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it.action     = t_action'($urandom_range(0, 3));
        it.network    = $urandom;
        it.prefix_len = t_len'($urandom_range(0, 63));
        it.host_count = {1'($urandom), 32'($urandom)};
        it.malformed  = 1'($urandom);
        return it;
    endfunction

    task automatic push_item(t_item it, bit known = 1'b0, t_result typed = '0);
        t_result predicted;
        int      gap;
        in_ch.valid      <= 1'b1;
        in_ch.action     <= it.action;
        in_ch.network    <= it.network;
        in_ch.prefix_len <= it.prefix_len;
        in_ch.host_count <= it.host_count;
        in_ch.malformed  <= it.malformed;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = predict_prefix(it);
        expected_results.push_back(known ? typed : predicted);
        sent_count++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic apply_limits(t_entries min_count, t_sum min_hosts, logic enforce);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MIN_COUNT;
        i_cfg_wdata <= CFG_W'(min_count);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MIN_HOSTS;
        i_cfg_wdata <= CFG_W'(min_hosts);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ENFORCE;
        i_cfg_wdata <= CFG_W'(enforce);
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cfg_min_count = min_count;
        cfg_min_hosts = min_hosts;
        cfg_enforce   = enforce;
    endtask

    // Clear, 1 to 12 items with random content (mostly adds), then finish.
    task automatic run_list_sequence();
        t_item it;
        int    adds;
        it = '{action: ACT_CLEAR, default: '0};
        push_item(it);
        adds = $urandom_range(1, 12);
        repeat (adds) begin
            case ($urandom_range(0, 19))
                0: begin
                    it = fresh_prefix();
                    if ($urandom_range(0, 1) != 0) begin
                        it.malformed = 1'b1;
                    end else begin
                        it.prefix_len = t_len'($urandom_range(33, 63));
                    end
                end
                1, 2: it = nested_prefix();
                3: begin
                    it        = noise_item();
                    it.action = ACT_UNUSED;
                end
                default: it = fresh_prefix();
            endcase
            push_item(it);
        end
        it = '{action: ACT_FINISH, default: '0};
        push_item(it);
    endtask

    // Loads every slot with a /24 of 4G hosts so that the total lands exactly on 2^40, then probes the full table.
    task automatic fill_table();
        t_item      it;
        logic [7:0] top;
        top = 8'($urandom);
        it  = '{action: ACT_CLEAR, default: '0};
        push_item(it);
        for (int k = 0; k < DEPTH; k++) begin
            if (k == DEPTH - 1) begin
                it = '{action: ACT_FINISH, default: '0};
                push_item(it);
            end
            it = '{ACT_ADD, {top, 8'(k), 8'h00}, 6'd24, HOSTS_4G, 1'b0};
            push_item(it);
        end
        it = '{action: ACT_FINISH, default: '0};
        push_item(it);
        // A full table wins over a malformed line.
        it = '{ACT_ADD, 32'h0000_0000, 6'd40, 33'd1, 1'b1};
        push_item(it);
        it = '{action: ACT_FINISH, default: '0};
        push_item(it);
        it = '{action: ACT_CLEAR, default: '0};
        push_item(it);
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 40) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 40) begin
                $display("%0t: result with nothing expected: status %0d entries %0d total %0d",
                         $time, out_ch.status, out_ch.entries_stored, out_ch.host_total);
            end
        end else begin
            want = expected_results.pop_front();
            compare_field("status", want.status, out_ch.status);
            compare_field("entries_stored", want.entries, out_ch.entries_stored);
            compare_field("host_total", want.total, out_ch.host_total);
            compare_field("list_ok", want.ok, out_ch.list_ok);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                check_result();
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 400;
            end else if (stall_left == 0 && !rx_calm && $urandom_range(0, 6) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_directed_row row;
        t_item         it;
        t_result       typed;
        int            phase_start;
        bit            hold_sent;
        bit            pause_done;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_MIN_COUNT;
        i_cfg_wdata      <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_CLEAR;
        in_ch.network    <= '0;
        in_ch.prefix_len <= '0;
        in_ch.host_count <= '0;
        in_ch.malformed  <= 1'b0;
        stored_n       = 0;
        host_sum       = '0;
        held_error     = ST_OK;
        cfg_min_count  = RST_MIN_COUNT;
        cfg_min_hosts  = RST_MIN_HOSTS;
        cfg_enforce    = 1'b1;
        mismatch_count = 0;
        sent_count     = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        long_hold_req  = 1'b0;
        hold_sent      = 1'b0;
        pause_done     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row   = directed_rows[r];
            it    = '{row.action, row.network, row.prefix_len, row.host_count, row.malformed};
            typed = '{row.status, row.entries, row.total, row.ok};
            push_item(it, row.known, typed);
        end

        drain();
        apply_limits(9'd256, SUM_1T, 1'b1);
        fill_table();

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: apply_limits(9'd0, 41'd0, 1'b1);
                1: apply_limits(9'd256, SUM_1T, 1'b1);
                2: apply_limits(t_entries'($urandom_range(0, 256)),
                                {1'b0, 8'($urandom), 32'($urandom)}, 1'b0);
                3: apply_limits(t_entries'($urandom_range(1, 10)),
                                {7'd0, 2'($urandom), 32'($urandom)}, 1'b1);
                4: apply_limits(RST_MIN_COUNT, RST_MIN_HOSTS, 1'b1);
                5: apply_limits(t_entries'($urandom_range(0, 256)),
                                {1'b0, 8'($urandom), 32'($urandom)}, 1'($urandom));
                default: apply_limits(9'd3, 41'd1, 1'b1);
            endcase
            tx_calm     = (phase == 0) || (phase == 5);
            rx_calm     = (phase == 0) || (phase == 4);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                // The receiver stops for a long stretch while items keep coming.
                if (phase == 2 && !hold_sent && sent_count - phase_start > 20) begin
                    long_hold_req = 1'b1;
                    hold_sent     = 1'b1;
                end
                if (phase == 3 && !pause_done && sent_count - phase_start > 30) begin
                    drain();
                    pause_done = 1'b1;
                end
                if ($urandom_range(0, 6) == 0) begin
                    push_item(noise_item());
                end else begin
                    run_list_sequence();
                end
            end
        end

        drain();
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ipv4_prefix_overlap_checker: match");
        end else begin
            $display("ipv4_prefix_overlap_checker: mismatch");
        end
        $finish;
    end

    // Several times the slowest legal run, with every add walking a full table.
    initial begin : watchdog
        #20ms;
        $display("ipv4_prefix_overlap_checker: mismatch");
        $finish;
    end

endmodule
